// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the HMAC-SHA256 stream block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/hmac_pkg.sv =====
// Shared types, constants and SHA-256 helper functions for the HMAC block.
// No dependencies.
`timescale 1ns / 1ps
package hmac_pkg;

	// Item class assigned by the front end
	typedef enum logic [1:0] {
		OP_IDLE     = 2'd0,
		OP_BYTE     = 2'd1,
		OP_END      = 2'd2,
		OP_BYTE_END = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} item_t;

	localparam int          KEY_WORDS  = 8;
	localparam int          CFG_IDX_W  = 4;
	localparam logic [31:0] IPAD       = 32'h36363636;
	localparam logic [31:0] OPAD       = 32'h5c5c5c5c;
	localparam logic [7:0]  PAD_BYTE   = 8'h80;
	localparam logic [31:0] PAD_WORD   = 32'h80000000;
	localparam logic [63:0] KEY_BITS   = 64'd512;
	localparam logic [63:0] OUTER_BITS = 64'd768;

	localparam logic [0:7][31:0] INIT_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Key block as sixteen big-endian words, XORed with a pad word
	function automatic logic [0:15][31:0] key_words(input logic [0:7][63:0] key,
			input logic [31:0] pad);
		logic [0:15][31:0] w;
		for (int t = 0; t < 16; t++) begin
			w[t] = (t % 2 == 1) ? (key[t / 2][31:0] ^ pad) : (key[t / 2][63:32] ^ pad);
		end
		return w;
	endfunction

endpackage

// ===== hdl/hmac_in_if.sv =====
// Input channel: at most one message byte per beat with its framing flags.
// No dependencies.
`timescale 1ns / 1ps
interface hmac_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last_byte;

	modport source (output valid, data_byte, has_byte, last_byte, input ready);
	modport sink (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

// ===== hdl/hmac_out_if.sv =====
// Output channel: one 64-bit tag word per beat.
// No dependencies.
`timescale 1ns / 1ps
interface hmac_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] tag_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, tag_word, word_index, last_word, input ready);
	modport sink (input valid, tag_word, word_index, last_word, output ready);
endinterface

// ===== hdl/hmac_fifo.sv =====
// Short item queue between front end and hash engine.
// Depends on hmac_pkg.
`timescale 1ns / 1ps
module hmac_fifo import hmac_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t pop_item,
	output logic  full,
	output logic  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== hdl/hmac_front.sv =====
// Front end: takes input beats, classifies them and pushes them to the queue.
// Depends on hmac_pkg and hmac_in_if.
`timescale 1ns / 1ps
module hmac_front import hmac_pkg::*; (
	hmac_in_if.sink in_ch,
	input  logic    q_full,
	output logic    q_push,
	output item_t   q_item
);
	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;

	// Classify by framing flags
	always_comb begin
		unique case ({in_ch.last_byte, in_ch.has_byte})
			2'b00:   q_item.op = OP_IDLE;
			2'b01:   q_item.op = OP_BYTE;
			2'b10:   q_item.op = OP_END;
			default: q_item.op = OP_BYTE_END;
		endcase
		q_item.data = in_ch.data_byte;
	end
endmodule

// ===== hdl/hmac_core.sv =====
// Hash engine: block assembly, padding, one SHA-256 round per cycle,
// inner and outer passes, tag output. Depends on hmac_pkg and hmac_out_if.
`timescale 1ns / 1ps
module hmac_core import hmac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [0:7][63:0]  key,
	input  logic              fifo_empty,
	input  item_t             fifo_item,
	output logic              fifo_pop,
	hmac_out_if.source        out_ch
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DATA  = 8'b0000_0010,
		S_PAD0  = 8'b0000_0100,
		S_PADZ  = 8'b0000_1000,
		S_INNER = 8'b0001_0000,
		S_OUTER = 8'b0010_0000,
		S_COMP  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t            state_q;
	state_t            ret_q;
	logic              fin_q;
	item_t             item_q;
	logic              phase_q;
	logic [5:0]        cnt_q;
	logic [63:0]       bitlen_q;
	logic [5:0]        rc_q;
	logic [1:0]        widx_q;
	logic              ovld_q;
	logic [0:15][31:0] w_q;
	logic [0:7][31:0]  h_q;
	logic [0:7][31:0]  v_q;
	logic [0:7][31:0]  dig_q;

	logic        item_has;
	logic        item_last;
	logic        byte_wr;
	logic [7:0]  byte_val;
	logic [31:0] wi;
	logic [31:0] t1;
	logic [31:0] t2;
	state_t      data_next;

	assign item_has  = (item_q.op == OP_BYTE) || (item_q.op == OP_BYTE_END);
	assign item_last = (item_q.op == OP_END) || (item_q.op == OP_BYTE_END);
	assign data_next = item_last ? S_PAD0 : S_IDLE;
	assign fifo_pop  = (state_q == S_IDLE) && !fin_q && !fifo_empty;

	// Byte lane writes into the block buffer
	always_comb begin
		byte_wr  = ((state_q == S_DATA) && item_has) || (state_q == S_PAD0)
			|| ((state_q == S_PADZ) && (cnt_q != 6'd56));
		byte_val = (state_q == S_DATA) ? item_q.data
			: ((state_q == S_PAD0) ? PAD_BYTE : 8'h00);
	end

	// Round datapath; schedule window shifts by one word a round
	always_comb begin
		wi = (rc_q[5:4] == 2'd0) ? w_q[0]
			: ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[rc_q] + wi;
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign out_ch.valid      = ovld_q;
	assign out_ch.tag_word   = {h_q[{widx_q, 1'b0}], h_q[{widx_q, 1'b1}]};
	assign out_ch.word_index = widx_q;
	assign out_ch.last_word  = (widx_q == 2'd3);

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			fin_q    <= 1'b0;
			item_q   <= '0;
			phase_q  <= 1'b0;
			cnt_q    <= '0;
			bitlen_q <= '0;
			rc_q     <= '0;
			widx_q   <= '0;
			ovld_q   <= 1'b0;
			w_q      <= '0;
			h_q      <= INIT_HASH;
			v_q      <= '0;
			dig_q    <= '0;
		end else begin
			if (byte_wr) begin
				w_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] <= byte_val;
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin_q) begin
				// feed-forward of the finished compression
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
				fin_q   <= 1'b0;
				state_q <= ret_q;
				if (ret_q == S_EMIT) begin
					ovld_q <= 1'b1;
					widx_q <= '0;
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (!fifo_empty) begin
							item_q <= fifo_item;
							if (!phase_q) begin
								w_q      <= key_words(key, IPAD);
								h_q      <= INIT_HASH;
								v_q      <= INIT_HASH;
								rc_q     <= '0;
								phase_q  <= 1'b1;
								cnt_q    <= '0;
								bitlen_q <= KEY_BITS;
								ret_q    <= S_DATA;
								state_q  <= S_COMP;
							end else begin
								state_q <= S_DATA;
							end
						end
					end
					S_DATA: begin
						if (item_has) begin
							bitlen_q <= bitlen_q + 64'd8;
						end
						if (item_has && (cnt_q == 6'd63)) begin
							v_q     <= h_q;
							rc_q    <= '0;
							ret_q   <= data_next;
							state_q <= S_COMP;
						end else begin
							state_q <= data_next;
						end
					end
					S_PAD0: begin
						if (cnt_q == 6'd63) begin
							v_q     <= h_q;
							rc_q    <= '0;
							ret_q   <= S_PADZ;
							state_q <= S_COMP;
						end else begin
							state_q <= S_PADZ;
						end
					end
					S_PADZ: begin
						if (cnt_q == 6'd56) begin
							w_q[14] <= bitlen_q[63:32];
							w_q[15] <= bitlen_q[31:0];
							v_q     <= h_q;
							rc_q    <= '0;
							cnt_q   <= '0;
							ret_q   <= S_INNER;
							state_q <= S_COMP;
						end else if (cnt_q == 6'd63) begin
							v_q     <= h_q;
							rc_q    <= '0;
							ret_q   <= S_PADZ;
							state_q <= S_COMP;
						end
					end
					S_INNER: begin
						dig_q   <= h_q;
						w_q     <= key_words(key, OPAD);
						h_q     <= INIT_HASH;
						v_q     <= INIT_HASH;
						rc_q    <= '0;
						ret_q   <= S_OUTER;
						state_q <= S_COMP;
					end
					S_OUTER: begin
						// inner digest already padded to one block
						w_q     <= {dig_q, PAD_WORD, 160'd0, OUTER_BITS};
						v_q     <= h_q;
						rc_q    <= '0;
						ret_q   <= S_EMIT;
						state_q <= S_COMP;
					end
					S_COMP: begin
						v_q <= {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1,
							v_q[4], v_q[5], v_q[6]};
						for (int i = 0; i < 15; i++) begin
							w_q[i] <= w_q[i + 1];
						end
						w_q[15] <= wi;
						rc_q    <= rc_q + 1'b1;
						if (rc_q == 6'd63) begin
							fin_q <= 1'b1;
						end
					end
					S_EMIT: begin
						if (out_ch.ready) begin
							if (widx_q == 2'd3) begin
								ovld_q  <= 1'b0;
								phase_q <= 1'b0;
								state_q <= S_IDLE;
							end else begin
								widx_q <= widx_q + 1'b1;
							end
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end
endmodule

// ===== hdl/hmac_sha256_stream_top.sv =====
// HMAC-SHA256 over a byte stream. The first beat of a message adds the inner key block
// compression, and each 64th byte adds a block compression (one round a cycle).
// Last beat: padding (plus a compression when the pad spills into a new block)
// plus three compressions, then 4 tag beats; queue of FIFO_DEPTH beats in front of the engine.
// Reset (async, active low): key clears to zero, queue empties, next beat starts a message.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hmac_sha256_stream_top import hmac_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hmac_in_if.sink              in_ch,
	hmac_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [63:0]          cfg_wdata
);
	logic [0:7][63:0] key_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	item_t            q_in;
	item_t            q_out;

	// Key registers; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(KEY_WORDS))) begin
			key_q[cfg_idx[2:0]] <= cfg_wdata;
		end
	end

	hmac_front u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_in)
	);

	hmac_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.pop_item  (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	hmac_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (key_q),
		.fifo_empty (q_empty),
		.fifo_item  (q_out),
		.fifo_pop   (q_pop),
		.out_ch     (out_ch)
	);

	`ASSERT_ALWAYS(a_no_push_full, clk, arst_n, !(q_push && q_full), "push into full queue")
	`ASSERT_ALWAYS(a_no_pop_empty, clk, arst_n, !(q_pop && q_empty), "pop from empty queue")
	`ASSERT_NEXT(a_tag_ends, clk, arst_n, out_ch.valid && out_ch.ready && out_ch.last_word, !out_ch.valid, "tag continues past last word")
endmodule

// ===== tb/tb_hmac_sha256_stream_top.sv =====
// Testbench for the HMAC-SHA256 byte-stream block: drives messages byte by byte,
// predicts each tag with its own SHA-256 and compares the four tag words.
// Depends on hmac_pkg, the two channel interfaces and hmac_sha256_stream_top.
`timescale 1ns / 1ps
module tb_hmac_sha256_stream_top import hmac_pkg::*;;

	localparam int RUN_LIMIT = 2000000;
	// cfg_idx is 4 bits wide, but the block has only eight key registers
	localparam logic [CFG_IDX_W-1:0] IDX_NONE = 4'd8;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [63:0] cfg_wdata;

	hmac_in_if in_ch();
	hmac_out_if out_ch();

	hmac_sha256_stream_top u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	typedef struct packed {
		logic [63:0] tag_word;
		logic [1:0]  word_index;
		logic        last_word;
	} tag_beat_t;

	// Predictor state
	logic [63:0] key_regs [8];
	logic [7:0]  msg_bytes [$];
	logic        msg_open;
	logic [63:0] msg_key_ipad [8];
	tag_beat_t   tag_queue [$];

	int mismatches, tags_seen, msgs_done;
	int cycle_count;
	bit hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d tag words pending",
				cycle_count, tag_queue.size());
			$display("FAIL hmac_sha256_stream_top");
			$finish;
		end
	end

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One SHA-256 compression of a 64-byte block into the chaining value
	function automatic void sha_block(ref logic [31:0] hv [8], input logic [7:0] blk [64]);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
		hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
	endfunction

	// SHA-256 of (key ^ pad) followed by the given bytes
	function automatic void keyed_digest(input logic [63:0] kb [8], input logic [7:0] pad,
			input logic [7:0] body [$], ref logic [31:0] hv [8]);
		logic [7:0] stream [$];
		logic [7:0] blk [64];
		logic [63:0] bits;
		for (int i = 0; i < 8; i++) hv[i] = INIT_HASH[i];
		for (int i = 0; i < 64; i++) stream.push_back(kb[i/8][63-8*(i%8) -: 8] ^ pad);
		foreach (body[i]) stream.push_back(body[i]);
		bits = 64'(stream.size()) * 8;
		stream.push_back(8'h80);
		while (stream.size() % 64 != 56) stream.push_back(8'h00);
		for (int i = 7; i >= 0; i--) stream.push_back(bits[8*i +: 8]);
		for (int s = 0; s < stream.size(); s += 64) begin
			for (int i = 0; i < 64; i++) blk[i] = stream[s+i];
			sha_block(hv, blk);
		end
	endfunction

	// Model one accepted beat; a last beat queues the four tag words
	function automatic void predict_beat(logic [7:0] data, logic has, logic last);
		logic [31:0] inner [8];
		logic [31:0] outer [8];
		logic [7:0] ib [$];
		if (!msg_open) begin
			msg_key_ipad = key_regs;
			msg_open = 1'b1;
			msg_bytes.delete();
		end
		if (has) msg_bytes.push_back(data);
		if (!last) return;
		keyed_digest(msg_key_ipad, 8'h36, msg_bytes, inner);
		for (int i = 0; i < 8; i++)
			for (int j = 3; j >= 0; j--) ib.push_back(inner[i][8*j +: 8]);
		keyed_digest(key_regs, 8'h5c, ib, outer);
		for (int k = 0; k < 4; k++)
			tag_queue.push_back('{{outer[2*k], outer[2*k+1]}, 2'(k), k == 3});
		msg_open = 1'b0;
		msgs_done++;
	endfunction

	// Sender: one beat, offered from a falling edge until accepted
	task automatic send_beat(logic [7:0] data, logic has, logic last);
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= data;
		in_ch.has_byte <= has;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		predict_beat(data, has, last);
		@(negedge clk);
		// random gap between bursts; valid stays high when no gap follows
		if ($urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic idle_sender();
		in_ch.valid <= 1'b0;
	endtask

	// Key write, also into the predictor's copy for valid indexes; cfg_we drops after each write
	task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < 8) key_regs[idx] = value;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		idle_sender();
		while (tag_queue.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_message(int len, logic [1:0] ends_with);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, (i == len - 1) && ends_with == 2'd1);
		end
		if (ends_with != 2'd1 || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_directed();
		// empty message under the all-zero reset key
		send_beat(8'h00, 1'b0, 1'b1);
		// extreme bytes, idle beat, then a last beat carrying a byte
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h5a, 1'b0, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'ha5, 1'b1, 1'b1);
		wait_drained();
		// all-ones key at every register, and writes to two missing registers
		for (int i = 0; i < 8; i++) write_key(CFG_IDX_W'(i), '1);
		write_key(IDX_NONE, 64'h0123_4567_89ab_cdef);
		write_key(4'hf, 64'h0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hff, 1'b1, 1'b1);
		// message lengths around the padding boundary
		wait_drained();
		send_message(55, 2'd1);
		send_message(56, 2'd1);
		// key change mid-message: the outer pass uses the new key
		send_beat(8'h11, 1'b1, 1'b0);
		wait_drained();
		// let the inner key block finish before touching the key
		repeat (80) @(negedge clk);
		write_key(4'd3, 64'hdead_beef_0000_0001);
		send_beat(8'h22, 1'b1, 1'b1);
		wait_drained();
	endtask

	// Fill the block while the receiver holds off
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				send_message(20, 2'd1);
				send_message(10, 2'd1);
			end
			begin
				repeat (1000) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		send_message(3, 2'd1);
		wait_drained();
	endtask

	task automatic test_random();
		int sent, len;
		sent = 0;
		while (sent < 140) begin
			if ($urandom_range(0, 4) == 0) begin
				wait_drained();
				for (int i = 0; i < 8; i++)
					write_key(CFG_IDX_W'(i), $urandom_range(0, 3) == 0 ? 64'h0 :
						{$urandom, $urandom});
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 12);
			send_message(len, 2'($urandom_range(1, 2)));
			sent += len + 1;
		end
		wait_drained();
	endtask

	// Receiver: stall pattern plus the long hold-off
	always @(negedge clk) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else if (hold_off) out_ch.ready <= 1'b0;
		else if (cycle_count % 200 < 60) out_ch.ready <= 1'b1;
		else out_ch.ready <= ($urandom_range(0, 2) != 0);
	end

	// Checker: compare each accepted tag word with the oldest expectation
	always @(posedge clk) begin
		tag_beat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			tags_seen++;
			if (tag_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tag word %h idx %0d", out_ch.tag_word,
						out_ch.word_index);
			end else begin
				want = tag_queue.pop_front();
				if (out_ch.tag_word !== want.tag_word || out_ch.word_index !== want.word_index
						|| out_ch.last_word !== want.last_word) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tag mismatch: exp %h/%0d/%b got %h/%0d/%b",
							want.tag_word, want.word_index, want.last_word,
							out_ch.tag_word, out_ch.word_index, out_ch.last_word);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		mismatches = 0;
		tags_seen = 0;
		msgs_done = 0;
		hold_off = 1'b0;
		msg_open = 1'b0;
		for (int i = 0; i < 8; i++) key_regs[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.has_byte = 1'b0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random();
		repeat (50) @(negedge clk);
		$display("covered %0d messages, %0d tag words, key changes incl. all-zero/all-ones",
			msgs_done, tags_seen);
		if (mismatches == 0 && tag_queue.size() == 0) begin
			$display("PASS hmac_sha256_stream_top");
		end else begin
			$display("%0d mismatches, %0d tag words missing", mismatches, tag_queue.size());
			$display("FAIL hmac_sha256_stream_top");
		end
		$finish;
	end
endmodule
